### hdl/wlwt_pkg.sv
`default_nettype none
package wlwt_pkg;
    localparam logic [1:0] MODE_NEW_DAY = 2'd0;
    localparam logic [1:0] MODE_JOIN    = 2'd1;
    localparam logic [1:0] MODE_SERVED  = 2'd2;
    localparam logic [1:0] MODE_DISCARD = 2'd3;

    localparam int UNIT_W  = 13;
    localparam int ANIM_W  = 32;
    localparam int DAY_W   = 16;
    localparam int AVG_W   = 24;
    localparam int FSUM_W  = 48;
    localparam int FCNT_W  = 32;
    localparam int TSUM_W  = 49;
    localparam int TCNT_W  = 33;
    localparam int NUM_W   = TSUM_W + 8;

    localparam logic [UNIT_W-1:0] UNIT_MAX = {UNIT_W{1'b1}};
    localparam logic [ANIM_W-1:0] ANIM_MAX = {ANIM_W{1'b1}};
    localparam logic [FSUM_W-1:0] FSUM_MAX = {FSUM_W{1'b1}};
    localparam logic [FCNT_W-1:0] FCNT_MAX = {FCNT_W{1'b1}};
    localparam logic [AVG_W-1:0]  AVG_MAX  = {AVG_W{1'b1}};

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  dividend;
        logic [TCNT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [AVG_W-1:0] quotient;
    } t_div_rsp;
endpackage
`default_nettype wire

### hdl/wlwt_table.sv
`default_nettype none
module wlwt_table
    import wlwt_pkg::*;
#(
    parameter int NUM_UNITS = 4096,
    parameter int ADDR_W    = 12
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DAY_W-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DAY_W-1:0]  o_rdata
);
    logic [DAY_W-1:0] r_mem [NUM_UNITS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### hdl/wlwt_div.sv
`default_nettype none
// restoring divider, one quotient bit a cycle, saturating to AVG_W bits
module wlwt_div
    import wlwt_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  r_num;
    logic [TCNT_W:0]   r_rem;
    logic [TCNT_W-1:0] r_den;
    logic [NUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [TCNT_W:0]   n_sh;
    logic              n_ge;

    assign n_sh = {r_rem[TCNT_W-1:0], r_num[NUM_W-1]};
    assign n_ge = n_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_req.start) begin
            r_num <= i_req.dividend;
            r_den <= i_req.divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= n_ge ? n_sh - {1'b0, r_den} : n_sh;
            r_quo <= {r_quo[NUM_W-2:0], n_ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = (r_quo[NUM_W-1:AVG_W] != '0) ? AVG_MAX : r_quo[AVG_W-1:0];
endmodule
`default_nettype wire

### hdl/waiting_list_wait_time_monitor_core.sv
`default_nettype none
// Join and removal items: S_READ, S_MOD, then S_DONE, which waits for a free output register.
// New-day item, enabled: S_WALK reads one table entry a cycle, then S_DIV starts a bit-serial
// divide awaited in S_WAITD, skipped when the divisor is zero; disabled: straight to S_DONE.
// One item in flight; a finished result waits in the output register while the next runs.
// Reset: synchronous, active low; a clearing pass then writes zero to every table entry,
// during which no item is accepted.
module waiting_list_wait_time_monitor_core
    import wlwt_pkg::*;
#(
    parameter int NUM_UNITS = 4096
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_wdata,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [1:0]        i_mode,
    input  wire logic [11:0]       i_unit_index,
    input  wire logic [DAY_W-1:0]  i_day,
    input  wire logic [15:0]       i_unit_size,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [UNIT_W-1:0]      o_waiting_units,
    output logic [ANIM_W-1:0]      o_waiting_animals,
    output logic [UNIT_W-1:0]      o_peak_units,
    output logic [ANIM_W-1:0]      o_peak_animals,
    output logic [DAY_W-1:0]       o_peak_wait_days,
    output logic [AVG_W-1:0]       o_average_wait,
    output logic                   o_changed
);
    localparam int ADDR_W = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
    localparam int CNT_W  = $clog2(NUM_UNITS + 1);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_READ  = 8'b0000_0100,
        S_MOD   = 8'b0000_1000,
        S_WALK  = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_WAITD = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state              r_state;
    logic                r_en;
    logic [1:0]          r_mode;
    logic [11:0]         r_idx;
    logic [DAY_W-1:0]    r_day;
    logic [15:0]         r_size;
    logic [CNT_W-1:0]    r_ptr;
    logic                r_rvalid;
    logic [UNIT_W-1:0]   r_units;
    logic [ANIM_W-1:0]   r_anim;
    logic [UNIT_W-1:0]   r_upeak;
    logic [ANIM_W-1:0]   r_apeak;
    logic [DAY_W-1:0]    r_wpeak;
    logic [FSUM_W-1:0]   r_fsum;
    logic [FCNT_W-1:0]   r_fcnt;
    logic [AVG_W-1:0]    r_avg;
    logic [DAY_W-1:0]    r_npeak;
    logic [TSUM_W-1:0]   r_wsum;
    logic [TCNT_W-1:0]   r_wcnt;
    logic                r_chg;
    logic                r_ovalid;

    logic                n_we;
    logic [ADDR_W-1:0]   n_waddr;
    logic [DAY_W-1:0]    n_wdata;
    logic [ADDR_W-1:0]   n_raddr;
    logic [DAY_W-1:0]    n_rdata;
    logic [DAY_W-1:0]    n_wait;
    logic                n_inrange;
    logic [ANIM_W:0]     n_asum;
    logic [UNIT_W-1:0]   n_units;
    logic [ANIM_W-1:0]   n_anim;
    logic [FSUM_W:0]     n_fsum;
    logic                n_load;
    t_div_req            n_dreq;
    t_div_rsp            n_drsp;

    wlwt_table #(.NUM_UNITS(NUM_UNITS), .ADDR_W(ADDR_W)) u_table (
        .i_clk  (i_clk),
        .i_we   (n_we),
        .i_waddr(n_waddr),
        .i_wdata(n_wdata),
        .i_raddr(n_raddr),
        .o_rdata(n_rdata)
    );

    wlwt_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (n_dreq),
        .o_rsp  (n_drsp)
    );

    assign o_ready   = (r_state == S_IDLE);
    assign n_load    = (r_state == S_DONE) && (!r_ovalid || i_ready);
    assign n_inrange = 32'(r_idx) < NUM_UNITS;
    assign n_wait    = (r_day >= n_rdata) ? r_day - n_rdata : '0;
    assign n_raddr   = (r_state == S_WALK) ? r_ptr[ADDR_W-1:0] : ADDR_W'(r_idx);
    assign n_asum    = {1'b0, r_anim} + (ANIM_W+1)'(r_size);
    assign n_fsum    = {1'b0, r_fsum} + (FSUM_W+1)'(n_wait);
    assign n_units   = (r_units == UNIT_MAX) ? r_units : r_units + 1'b1;
    assign n_anim    = n_asum[ANIM_W] ? ANIM_MAX : n_asum[ANIM_W-1:0];

    always_comb begin
        n_we    = 1'b0;
        n_waddr = ADDR_W'(r_idx);
        n_wdata = '0;
        if (r_state == S_CLEAR) begin
            n_we    = 1'b1;
            n_waddr = r_ptr[ADDR_W-1:0];
        end else if (r_state == S_MOD && n_inrange) begin
            if (r_mode == MODE_JOIN) begin
                n_we    = (r_day != '0) && (n_rdata == '0);
                n_wdata = r_day;
            end else begin
                n_we = n_rdata != '0;
            end
        end
    end

    always_comb begin
        n_dreq.start    = (r_state == S_DIV);
        n_dreq.dividend = {r_wsum + TSUM_W'(r_fsum), 8'h00};
        n_dreq.divisor  = r_wcnt + TCNT_W'(r_fcnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_ptr    <= '0;
            r_en     <= 1'b0;
            r_ovalid <= 1'b0;
            r_rvalid <= 1'b0;
            r_units  <= '0;
            r_anim   <= '0;
            r_upeak  <= '0;
            r_apeak  <= '0;
            r_wpeak  <= '0;
            r_fsum   <= '0;
            r_fcnt   <= '0;
            r_avg    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_en <= i_cfg_wdata;
            end
            if (n_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_ptr <= r_ptr + 1'b1;
                    if (r_ptr == CNT_W'(NUM_UNITS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_mode <= i_mode;
                        r_idx  <= i_unit_index;
                        r_day  <= i_day;
                        r_size <= i_unit_size;
                        r_chg  <= 1'b0;
                        if (i_mode != MODE_NEW_DAY) begin
                            r_state <= S_READ;
                        end else if (r_en) begin
                            r_ptr    <= '0;
                            r_rvalid <= 1'b0;
                            r_npeak  <= r_wpeak;
                            r_wsum   <= '0;
                            r_wcnt   <= '0;
                            r_state  <= S_WALK;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_READ: r_state <= S_MOD;
                S_MOD: begin
                    r_state <= S_DONE;
                    if (n_inrange) begin
                        if (r_mode == MODE_JOIN) begin
                            if (r_day != '0 && n_rdata == '0) begin
                                r_chg   <= 1'b1;
                                r_units <= n_units;
                                r_anim  <= n_anim;
                                if (n_units > r_upeak) r_upeak <= n_units;
                                if (n_anim > r_apeak)  r_apeak <= n_anim;
                            end
                        end else if (n_rdata != '0) begin
                            r_chg  <= 1'b1;
                            r_fsum <= n_fsum[FSUM_W] ? FSUM_MAX : n_fsum[FSUM_W-1:0];
                            if (r_fcnt != FCNT_MAX) r_fcnt <= r_fcnt + 1'b1;
                            if (r_units != '0) r_units <= r_units - 1'b1;
                            r_anim <= (r_anim > ANIM_W'(r_size)) ?
                                      r_anim - ANIM_W'(r_size) : '0;
                        end
                    end
                end
                S_WALK: begin
                    if (r_ptr != CNT_W'(NUM_UNITS)) begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                    r_rvalid <= r_ptr != CNT_W'(NUM_UNITS);
                    if (r_rvalid && n_rdata != '0) begin
                        if (n_wait > r_npeak) r_npeak <= n_wait;
                        r_wsum <= r_wsum + TSUM_W'(n_wait);
                        r_wcnt <= r_wcnt + 1'b1;
                    end
                    if (r_ptr == CNT_W'(NUM_UNITS) && !r_rvalid) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (n_dreq.divisor == '0) begin
                        r_chg   <= (r_npeak != r_wpeak) || (r_avg != '0);
                        r_wpeak <= r_npeak;
                        r_avg   <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_WAITD;
                    end
                end
                S_WAITD: begin
                    if (n_drsp.done) begin
                        r_chg   <= (r_npeak != r_wpeak) || (n_drsp.quotient != r_avg);
                        r_wpeak <= r_npeak;
                        r_avg   <= n_drsp.quotient;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (n_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            o_waiting_units   <= r_units;
            o_waiting_animals <= r_anim;
            o_peak_units      <= r_upeak;
            o_peak_animals    <= r_apeak;
            o_peak_wait_days  <= r_wpeak;
            o_average_wait    <= r_avg;
            o_changed         <= r_chg;
        end
    end

    assign o_valid = r_ovalid;
endmodule
`default_nettype wire
